FILE: rtl/stcl_pkg.sv
package stcl_pkg;

  localparam logic [1:0] FUNC_ACTIVATE = 2'd0;
  localparam logic [1:0] FUNC_LEARN    = 2'd1;
  localparam logic [1:0] FUNC_LOAD     = 2'd2;
  localparam logic [1:0] FUNC_NOP      = 2'd3;

  localparam logic [1:0] MODE_EXC   = 2'd0;
  localparam logic [1:0] MODE_INH   = 2'd1;
  localparam logic [1:0] MODE_PLAIN = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_MAXW = 1'b1;

  localparam logic [1:0]  MODE_RESET = MODE_PLAIN;
  localparam logic [30:0] MAXW_RESET = 31'd65536;

  localparam logic signed [32:0] Q_AMPA    = 33'sd52429;
  localparam logic signed [32:0] Q_GABAA   = 33'sd56164;
  localparam logic signed [32:0] Q_LONGTAU = 33'sd65077;
  localparam logic signed [32:0] Q_PLTAU   = 33'sd62259;
  localparam logic signed [32:0] Q_RATE    = 33'sd6554;
  localparam logic signed [31:0] Q_SHORT_G = -32'sd492;
  localparam logic signed [31:0] Q_LONG_G  = -32'sd49;
  localparam logic signed [31:0] Q_PL_BASE = 32'sd6554;
  localparam logic signed [32:0] V_OFS_80  = 33'sd5242880;
  localparam logic signed [32:0] V_OFS_70  = 33'sd4587520;
  localparam logic signed [32:0] V_OFS_90  = 33'sd5898240;
  localparam logic [63:0] GATE_DEN_OFS = 64'd3600 << 32;
  localparam logic [63:0] GATE_NUM     = 64'd3600 << 48;

  typedef struct packed {
    logic [1:0]          func;
    logic [9:0]          syn_index;
    logic                pre_spike;
    logic                post_spike;
    logic signed [31:0]  post_voltage;
    logic signed [31:0]  post_trace;
    logic signed [31:0]  weight_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] contribution;
    logic signed [31:0] weight_out;
  } result_t;

  typedef struct packed {
    in_item_t item;
    logic     in_range;
  } job_t;

  typedef struct packed {
    logic               base_pos;
    logic signed [31:0] weight;
    logic signed [31:0] short_tr;
    logic signed [31:0] long_tr;
    logic signed [31:0] plastic_tr;
  } syn_entry_t;

  // Q16.16 product: floor division by 2^16, then saturation.
  function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = p >>> 16;
    if (s > 66'sh0_7FFF_FFFF) qsat = 32'sh7FFF_FFFF;
    else if (s < -66'sh0_8000_0000) qsat = -32'sh8000_0000;
    else qsat = s[31:0];
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    if (x > 34'sh0_7FFF_FFFF) sat34 = 32'sh7FFF_FFFF;
    else if (x < -34'sh0_8000_0000) sat34 = -32'sh8000_0000;
    else sat34 = x[31:0];
  endfunction

endpackage

FILE: rtl/stcl_ram.sv
module stcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: rtl/stcl_front.sv
module stcl_front #(
  parameter int SYNAPSES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  stcl_pkg::in_item_t item_i,
  output logic              job_valid_o,
  output stcl_pkg::job_t    job_o,
  input  logic              job_pop_i
);
  import stcl_pkg::*;

  job_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;
  job_t       job_new;

  assign full_o      = (count_q == 2'd2);
  assign job_valid_o = (count_q != 2'd0);
  assign job_o       = slot_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = job_pop_i && job_valid_o;

  always_comb begin
    job_new.item     = item_i;
    job_new.in_range = (32'(item_i.syn_index) < 32'(SYNAPSES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= job_new;
  end
endmodule

FILE: rtl/stcl_back.sv
module stcl_back #(
  parameter int SYNAPSES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  stcl_pkg::job_t    job_i,
  output logic              job_pop_o,
  input  logic [1:0]        mode_i,
  input  logic [30:0]       wbound_i,
  output logic              empty_o,
  input  logic              pop_i,
  output stcl_pkg::result_t result_o
);
  import stcl_pkg::*;

  localparam int AW = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
  localparam int EW = $bits(syn_entry_t);

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_RD = 5'd1,   ST_DEC = 5'd2,  ST_DIVI = 5'd3;
  localparam logic [4:0] ST_DIV  = 5'd4,  ST_LV = 5'd5,   ST_ST  = 5'd6,  ST_LT   = 5'd7;
  localparam logic [4:0] ST_PT   = 5'd8,  ST_A1 = 5'd9,   ST_A2  = 5'd10, ST_B1   = 5'd11;
  localparam logic [4:0] ST_B2   = 5'd12, ST_SUM = 5'd13, ST_L1  = 5'd14, ST_L2   = 5'd15;
  localparam logic [4:0] ST_L3   = 5'd16, ST_L4 = 5'd17,  ST_OUT = 5'd18;

  logic [4:0]          state_q, state_d;
  job_t                cur_q;
  syn_entry_t          ent_q, wr_ent, ent;
  logic [EW-1:0]       rdata;
  logic                we;
  logic signed [65:0]  prod_q;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [31:0]  pq, sv_q, lv_q, st_q, lt_q, pt_q, acc_q, da_q;
  logic [63:0]         rem_q;
  logic [79:0]         dsh_q;
  logic [16:0]         quo_q;
  logic [4:0]          cnt_q;
  result_t             res_q, res_d, out_q;
  logic                out_valid_q, res_load;
  logic signed [31:0]  v, w, wnew, dbv, gate;
  logic signed [32:0]  a33, ua33, vsum70, vsum90;
  logic                trial_ok, pre, post, bp;
  logic signed [33:0]  room34, wsum;

  stcl_ram #(.WIDTH(EW), .DEPTH(SYNAPSES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(cur_q.item.syn_index)),
    .wdata_i (wr_ent),
    .raddr_i (AW'(cur_q.item.syn_index)),
    .rdata_o (rdata)
  );

  // While decoding, the entry is still on the RAM output and not yet in ent_q.
  assign ent  = (state_q == ST_DEC) ? syn_entry_t'(rdata) : ent_q;
  assign v    = cur_q.item.post_voltage;
  assign pre  = cur_q.item.pre_spike;
  assign post = cur_q.item.post_spike;
  assign w    = ent.weight;
  assign bp   = ent.base_pos;
  assign pq   = qsat(prod_q);
  assign a33  = 33'(v) + V_OFS_80;
  assign ua33 = a33[32] ? -a33 : a33;
  assign vsum70 = 33'(v) + V_OFS_70;
  assign vsum90 = 33'(v) + V_OFS_90;
  assign gate = 32'sd65536 - $signed({15'd0, quo_q});
  assign trial_ok = ({16'd0, rem_q} >= dsh_q);
  assign room34 = $signed({3'd0, wbound_i}) - 34'(w);
  assign dbv  = post ? pq : 32'sd0;
  assign wsum = 34'(w) + 34'(da_q) - 34'(dbv);
  assign wnew = sat34(wsum);

  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  always_comb begin
    state_d  = state_q;
    mul_a    = '0;
    mul_b    = '0;
    we       = 1'b0;
    wr_ent   = ent_q;
    res_d    = res_q;
    res_load = 1'b0;
    case (state_q)
      ST_IDLE: if (job_valid_i) state_d = ST_RD;
      ST_RD:   state_d = ST_DEC;
      ST_DEC: begin
        res_load = 1'b1;
        res_d.contribution = '0;
        res_d.weight_out   = w;
        state_d = ST_OUT;
        if (!cur_q.in_range) begin
          res_d.weight_out = '0;
        end else if (cur_q.item.func == FUNC_LOAD) begin
          we = 1'b1;
          wr_ent.base_pos   = (cur_q.item.weight_in > 32'sd0);
          wr_ent.weight     = cur_q.item.weight_in;
          wr_ent.short_tr   = '0;
          wr_ent.long_tr    = '0;
          wr_ent.plastic_tr = '0;
          res_d.weight_out  = cur_q.item.weight_in;
        end else if (cur_q.item.func == FUNC_ACTIVATE && bp) begin
          if (mode_i == MODE_EXC) begin
            res_load = 1'b0;
            mul_a = ua33;
            mul_b = ua33;
            state_d = ST_DIVI;
          end else if (mode_i == MODE_INH) begin
            res_load = 1'b0;
            state_d = ST_ST;
          end else begin
            res_d.contribution = pre ? w : 32'sd0;
          end
        end else if (cur_q.item.func == FUNC_LEARN && bp) begin
          res_load = 1'b0;
          mul_a = 33'(sat34(room34));
          mul_b = 33'(ent.plastic_tr);
          state_d = ST_L1;
        end
      end
      ST_DIVI: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == 5'd0) state_d = ST_LV;
      ST_LV: begin
        mul_a = 33'(gate);
        mul_b = 33'(v);
        state_d = ST_ST;
      end
      ST_ST: begin
        mul_a = 33'(ent_q.short_tr);
        mul_b = (mode_i == MODE_EXC) ? Q_AMPA : Q_GABAA;
        state_d = ST_LT;
      end
      ST_LT: begin
        mul_a = 33'(ent_q.long_tr);
        mul_b = Q_LONGTAU;
        state_d = ST_PT;
      end
      ST_PT: begin
        mul_a = 33'(ent_q.plastic_tr);
        mul_b = Q_PLTAU;
        state_d = ST_A1;
      end
      ST_A1: begin
        mul_a = 33'(st_q);
        mul_b = 33'(sv_q);
        state_d = ST_A2;
      end
      ST_A2: begin
        mul_a = 33'(pq);
        mul_b = 33'(w);
        state_d = ST_B1;
      end
      ST_B1: begin
        mul_a = 33'(lt_q);
        mul_b = 33'(lv_q);
        state_d = ST_B2;
      end
      ST_B2: begin
        mul_a = 33'(pq);
        mul_b = 33'(w);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        we = 1'b1;
        wr_ent.short_tr   = st_q;
        wr_ent.long_tr    = lt_q;
        wr_ent.plastic_tr = pt_q;
        res_load = 1'b1;
        res_d.contribution = sat34(34'(acc_q) + 34'(pq));
        res_d.weight_out   = w;
        state_d = ST_OUT;
      end
      ST_L1: begin
        mul_a = 33'(pq);
        mul_b = Q_RATE;
        state_d = ST_L2;
      end
      ST_L2: begin
        mul_a = 33'(w);
        mul_b = 33'(cur_q.item.post_trace);
        state_d = ST_L3;
      end
      ST_L3: begin
        mul_a = 33'(pq);
        mul_b = Q_RATE;
        state_d = ST_L4;
      end
      ST_L4: begin
        we = 1'b1;
        wr_ent.weight = wnew;
        res_load = 1'b1;
        res_d.contribution = '0;
        res_d.weight_out   = wnew;
        state_d = ST_OUT;
      end
      ST_OUT: if (!out_valid_q || pop_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && (!out_valid_q || pop_i)) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (job_pop_o) cur_q <= job_i;
    if (we) ent_q <= wr_ent;
    else if (state_q == ST_DEC) ent_q <= syn_entry_t'(rdata);
    if (state_q == ST_DEC) begin
      sv_q  <= (mode_i == MODE_EXC) ? v : sat34(34'(vsum70));
      lv_q  <= sat34(34'(vsum90));
    end
    if (res_load) res_q <= res_d;
    if (state_q == ST_OUT && (!out_valid_q || pop_i)) out_q <= res_q;
    case (state_q)
      ST_DIVI: begin
        dsh_q <= {prod_q[63:0] + GATE_DEN_OFS, 16'd0};
        rem_q <= GATE_NUM;
        quo_q <= '0;
        cnt_q <= 5'd16;
      end
      ST_DIV: begin
        if (trial_ok) rem_q <= rem_q - dsh_q[63:0];
        quo_q <= {quo_q[15:0], trial_ok};
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q - 5'd1;
      end
      // The gated long voltage product is on the multiplier output here.
      ST_ST: if (mode_i == MODE_EXC) lv_q <= pq;
      ST_LT: st_q  <= pre ? Q_SHORT_G : pq;
      ST_PT: lt_q  <= pre ? Q_LONG_G : pq;
      ST_A1: pt_q  <= pre ? Q_PL_BASE : pq;
      ST_B1: acc_q <= pq;
      ST_L2: da_q  <= pre ? pq : 32'sd0;
      default: ;
    endcase
  end
endmodule

FILE: rtl/synapse_trace_conductance_and_learning_top.sv
// Synapse trace engine: one item in, one result out, in the same order.
// Items enter through a queue-like port (push/full): an item is taken at a
// clock edge with push high and full low. Results leave through a second
// queue-like port (empty/pop): the oldest result stands on result_o while
// empty is low and is taken with pop high.
// A two-entry input queue sits between the accepting front end and the
// sequencer, so items keep being taken while a result waits to be popped.
// Each item is handled alone by the sequencer, which reads the synapse
// entry from RAM, runs its steps through one shared 33x33 multiplier and,
// for the excitatory mode, a restoring divider giving one quotient bit per
// cycle.
// The user must write registers via the APB port only while the block is
// idle; the block does not check it. synapse_mode at 0, weight bound at 4.
// Reset empties both queues and restores the registers; the synapse RAM is
// not cleared and each entry must be loaded before use.
// An unpopped result holds the sequencer when the next result is ready.
module synapse_trace_conductance_and_learning_top #(
  parameter int SYNAPSES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  stcl_pkg::in_item_t in_item_i,
  output logic               empty,
  input  logic               pop,
  output stcl_pkg::result_t  result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import stcl_pkg::*;

  logic        job_valid, job_pop;
  job_t        job;
  logic [1:0]  mode_q;
  logic [30:0] maxw_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_MODE) ? {30'd0, mode_q} : {1'b0, maxw_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
      maxw_q <= MAXW_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_MODE) mode_q <= pwdata[1:0];
      else maxw_q <= pwdata[30:0];
    end
  end

  stcl_front #(.SYNAPSES(SYNAPSES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  stcl_back #(.SYNAPSES(SYNAPSES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .job_pop_o    (job_pop),
    .mode_i       (mode_q),
    .wbound_i     (maxw_q),
    .empty_o      (empty),
    .pop_i        (pop),
    .result_o     (result_o)
  );
endmodule

FILE: rtl/stcl_checker.sv
module stcl_assert (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input logic              pready,
  input stcl_pkg::result_t result_o
);
  // A waiting result stays until it is popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty) else $error("result dropped before pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(result_o)) else $error("waiting result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");

  // No result can be ready in the first cycle after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> empty) else $error("result present straight after reset");
endmodule

bind synapse_trace_conductance_and_learning_top stcl_assert u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty    (empty),
  .pop      (pop),
  .pready   (pready),
  .result_o (result_o)
);

FILE: tb/stcl_checker.sv
`timescale 1ns / 1ps

module stcl_checker
  import stcl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  in_item_t    in_item_i,
  input  logic        empty,
  input  logic        pop,
  input  result_t     result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          pending
);

  logic [1:0]         mode_q;
  logic [30:0]        maxw_q;
  logic signed [31:0] weight_mem  [1024];
  logic signed [31:0] short_mem   [1024];
  logic signed [31:0] long_mem    [1024];
  logic signed [31:0] plastic_mem [1024];
  bit                 base_pos_mem[1024];
  result_t            expected_q[$];

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Arithmetic shift of the exact product rounds towards minus infinity.
  function automatic logic signed [31:0] qprod(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> 16);
  endfunction

  function automatic logic signed [31:0] nmda_gated_voltage(input logic signed [31:0] v);
    longint          a;
    longint unsigned ua;
    longint unsigned den;
    longint unsigned q;
    logic signed [31:0] g;
    a   = longint'(v) + 64'sd5242880;
    ua  = (a < 0) ? -a : a;
    den = ua * ua + GATE_DEN_OFS;
    q   = GATE_NUM / den;
    g   = 32'(64'sd65536 - longint'(q));
    return qprod(g, v);
  endfunction

  function automatic result_t synapse_response(input in_item_t it);
    result_t            r;
    int                 k;
    logic signed [31:0] w, sv, lv, st, lt;
    longint             delta;
    k = int'(it.syn_index);
    r.contribution = '0;
    if (it.func == FUNC_LOAD) begin
      weight_mem[k]   = it.weight_in;
      base_pos_mem[k] = it.weight_in > 0;
      short_mem[k]    = '0;
      long_mem[k]     = '0;
      plastic_mem[k]  = '0;
    end else if (it.func == FUNC_ACTIVATE && base_pos_mem[k]) begin
      w = weight_mem[k];
      if (mode_q == MODE_EXC || mode_q == MODE_INH) begin
        if (mode_q == MODE_EXC) begin
          sv = it.post_voltage;
          lv = nmda_gated_voltage(it.post_voltage);
        end else begin
          sv = clamp32(longint'(it.post_voltage) + 64'sd4587520);
          lv = clamp32(longint'(it.post_voltage) + 64'sd5898240);
        end
        st = it.pre_spike ? Q_SHORT_G
                          : qprod(short_mem[k], (mode_q == MODE_EXC) ? 32'sd52429 : 32'sd56164);
        lt = it.pre_spike ? Q_LONG_G : qprod(long_mem[k], 32'sd65077);
        short_mem[k]   = st;
        long_mem[k]    = lt;
        plastic_mem[k] = it.pre_spike ? Q_PL_BASE : qprod(plastic_mem[k], 32'sd62259);
        r.contribution = clamp32(longint'(qprod(qprod(st, sv), w))
                                 + longint'(qprod(qprod(lt, lv), w)));
      end else begin
        r.contribution = it.pre_spike ? w : '0;
      end
    end else if (it.func == FUNC_LEARN && base_pos_mem[k]) begin
      w     = weight_mem[k];
      delta = 0;
      if (it.pre_spike)
        delta += qprod(qprod(clamp32(longint'(maxw_q) - longint'(w)), plastic_mem[k]),
                       32'sd6554);
      if (it.post_spike)
        delta -= qprod(qprod(w, it.post_trace), 32'sd6554);
      weight_mem[k] = clamp32(longint'(w) + delta);
    end
    r.weight_out = weight_mem[k];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      mode_q     <= MODE_RESET;
      maxw_q     <= MAXW_RESET;
      expected_q.delete();
      mismatches = 0;
      pending    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MODE) mode_q <= pwdata[1:0];
        else maxw_q <= pwdata[30:0];
      end
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", result_o.weight_out, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (result_o.contribution !== want.contribution)
            report_mismatch("contribution", result_o.contribution, want.contribution);
          if (result_o.weight_out !== want.weight_out)
            report_mismatch("weight_out", result_o.weight_out, want.weight_out);
        end
      end
      if (push && !full) expected_q.push_back(synapse_response(in_item_i));
      pending <= expected_q.size();
    end
  end

endmodule

FILE: tb/tb_synapse_trace_conductance_and_learning_top.sv
`timescale 1ns / 1ps

module tb_synapse_trace_conductance_and_learning_top;
  import stcl_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  bit loaded[1024];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  synapse_trace_conductance_and_learning_top i_dut (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  stcl_checker i_checker (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .result_o,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .mismatches, .pending
  );

  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Holds the request until the block takes it; full only moves at rising edges.
  task automatic send_request(input in_item_t it);
    logic was_full;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    if (it.func == FUNC_LOAD) loaded[it.syn_index] = 1'b1;
    do begin
      was_full = full;
      @(negedge clk_i);
    end while (was_full);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic in_item_t make_item(input logic [1:0] func, input int idx,
                                         input bit pre, input bit post,
                                         input logic [31:0] v, input logic [31:0] tr,
                                         input logic [31:0] w);
    in_item_t it;
    it.func         = func;
    it.syn_index    = idx[9:0];
    it.pre_spike    = pre;
    it.post_spike   = post;
    it.post_voltage = v;
    it.post_trace   = tr;
    it.weight_in    = w;
    return it;
  endfunction

  function automatic logic [31:0] pick_voltage();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'(($urandom_range(160) - 100) * 65536 + $urandom_range(65535));
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int          idx;
    int          roll;
    logic [31:0] w;
    // A small pool of synapses lets traces build up over many requests.
    idx  = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(15);
    roll = $urandom_range(99);
    case ($urandom_range(3))
      0: w = $urandom;
      1: w = -$urandom_range(131072);
      default: w = $urandom_range(262144);
    endcase
    it = make_item(FUNC_ACTIVATE, idx, $urandom_range(1), $urandom_range(1),
                   pick_voltage(),
                   ($urandom_range(1) != 0) ? $urandom : 32'($urandom_range(131072) - 65536),
                   w);
    if (!loaded[idx] || roll < 12) it.func = FUNC_LOAD;
    else if (roll < 60) it.func = FUNC_ACTIVATE;
    else if (roll < 95) it.func = FUNC_LEARN;
    else it.func = FUNC_NOP;
    return it;
  endfunction

  initial begin
    logic [1:0]  mode_sel [6] = '{MODE_EXC, MODE_INH, MODE_PLAIN, MODE_SPARE, MODE_EXC,
                                  MODE_INH};
    logic [31:0] maxw_sel [6] = '{32'h7FFF_FFFF, 32'd0, 32'd65536, 32'd131072, 32'd0,
                                  32'h7FFF_FFFF};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: weight extremes, every function and the voltage extremes.
    send_request(make_item(FUNC_LOAD, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
    send_request(make_item(FUNC_LOAD, 1023, 0, 0, 0, 0, 32'h8000_0000));
    send_request(make_item(FUNC_LOAD, 1, 0, 0, 0, 0, 32'd0));
    send_request(make_item(FUNC_LOAD, 2, 0, 0, 0, 0, 32'd1));
    send_request(make_item(FUNC_LOAD, 3, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65536));
    send_request(make_item(FUNC_ACTIVATE, 0, 1, 0, 32'h7FFF_FFFF, 0, 0));
    send_request(make_item(FUNC_ACTIVATE, 1023, 1, 0, 0, 0, 0));
    send_request(make_item(FUNC_LEARN, 1, 1, 1, 0, 32'h7FFF_FFFF, 0));
    send_request(make_item(FUNC_LEARN, 3, 1, 1, 0, 32'h8000_0000, 0));
    send_request(make_item(FUNC_NOP, 3, 1, 1, 0, 0, 0));
    send_request(make_item(FUNC_ACTIVATE, 3, 0, 0, 32'h8000_0000, 0, 0));
    drain();
    write_reg(REG_MODE, MODE_EXC);
    write_reg(REG_MAXW, 32'h7FFF_FFFF);
    send_request(make_item(FUNC_ACTIVATE, 3, 1, 0, 32'hFFB0_0000, 0, 0));
    send_request(make_item(FUNC_ACTIVATE, 3, 0, 0, 32'h8000_0000, 0, 0));
    send_request(make_item(FUNC_ACTIVATE, 0, 1, 0, 32'h7FFF_FFFF, 0, 0));
    send_request(make_item(FUNC_LEARN, 0, 1, 1, 0, 32'h7FFF_FFFF, 0));
    send_request(make_item(FUNC_LEARN, 3, 1, 0, 0, 0, 0));
    drain();
    write_reg(REG_MODE, MODE_INH);
    send_request(make_item(FUNC_ACTIVATE, 3, 0, 0, 32'h7FFF_FFFF, 0, 0));
    send_request(make_item(FUNC_ACTIVATE, 3, 1, 0, 32'h8000_0000, 0, 0));
    send_request(make_item(FUNC_ACTIVATE, 2, 1, 0, 32'hFFBA_0000, 0, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MODE, mode_sel[ph]);
      write_reg(REG_MAXW, (ph == 3) ? ($urandom & 32'h7FFF_FFFF) : maxw_sel[ph]);
      case (ph / 2)
        0: begin send_idle_pct = 23; recv_idle_pct = 88; end
        1: begin send_idle_pct = 88; recv_idle_pct = 23; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (172) send_request(random_item());
      drain();
    end

    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/stcl_pkg.sv
rtl/stcl_ram.sv
rtl/stcl_front.sv
rtl/stcl_back.sv
rtl/synapse_trace_conductance_and_learning_top.sv
rtl/stcl_checker.sv
tb/stcl_checker.sv
tb/tb_synapse_trace_conductance_and_learning_top.sv
